// ----- src/murmur3_32_byte_stream_hash_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the murmur3 byte stream hash.
// Used by the file that checks the block's port behavior.
// ----------------------------------------------------------------------------
`ifndef MURMUR3_32_BYTE_STREAM_HASH_DEFINES_SVH
`define MURMUR3_32_BYTE_STREAM_HASH_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MM3_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MM3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/mm3_pkg.sv -----
// ----------------------------------------------------------------------------
// mm3_pkg
// Constants, datapath operations and control types of the murmur3 hash.
// ----------------------------------------------------------------------------
package mm3_pkg;

	localparam logic [31:0] MM3_C1 = 32'hcc9e2d51;
	localparam logic [31:0] MM3_C2 = 32'h1b873593;
	localparam logic [31:0] MM3_N  = 32'he6546b64;
	localparam logic [31:0] MM3_F1 = 32'h85ebca6b;
	localparam logic [31:0] MM3_F2 = 32'hc2b2ae35;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_SCR1,
		OP_SCR2,
		OP_MIX,
		OP_FIN1,
		OP_FIN2,
		OP_OUT
	} op_t;

	typedef struct packed {
		op_t  op;
		logic load;
		logic use_x;
	} cmd_t;

	typedef struct packed {
		logic blk_done;
		logic tail_nz;
		logic out_busy;
	} sts_t;

endpackage

// ----- src/mm3_ctrl.sv -----
// ----------------------------------------------------------------------------
// mm3_ctrl
// Sequencer that steps the shared multiplier through block mixing and
// finalization and owns the input ready.
// ----------------------------------------------------------------------------
module mm3_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	input  logic          s_axis_tlast,
	input  logic          byte_valid,
	output logic          s_axis_tready,
	input  mm3_pkg::sts_t sts,
	output mm3_pkg::cmd_t cmd
);
	import mm3_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCR1,
		ST_SCR2,
		ST_MIX,
		ST_FIN1,
		ST_FIN2,
		ST_OUT
	} state_t;

	state_t state_q, state_d;
	logic   blk_q, blk_d;
	logic   last_q, last_d;
	logic   tail_q, tail_d;
	logic   tready_q;
	logic   load;

	assign load = s_axis_tvalid & tready_q & (byte_valid | s_axis_tlast);

	always_comb begin
		state_d = state_q;
		blk_d   = blk_q;
		last_d  = last_q;
		tail_d  = tail_q;
		case (state_q)
			ST_IDLE: begin
				if (load) begin
					last_d = s_axis_tlast;
					blk_d  = sts.blk_done;
					tail_d = 1'b0;
					if (sts.blk_done) begin
						state_d = ST_SCR1;
					end else if (s_axis_tlast) begin
						tail_d  = sts.tail_nz;
						state_d = sts.tail_nz ? ST_SCR1 : ST_FIN1;
					end
				end
			end
			ST_SCR1: state_d = ST_SCR2;
			ST_SCR2: state_d = blk_q ? ST_MIX : ST_FIN1;
			ST_MIX:  state_d = last_q ? ST_FIN1 : ST_IDLE;
			ST_FIN1: state_d = ST_FIN2;
			ST_FIN2: state_d = ST_OUT;
			ST_OUT: begin
				if (!sts.out_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.load  = load;
		cmd.use_x = tail_q;
		case (state_q)
			ST_SCR1: cmd.op = OP_SCR1;
			ST_SCR2: cmd.op = OP_SCR2;
			ST_MIX:  cmd.op = OP_MIX;
			ST_FIN1: cmd.op = OP_FIN1;
			ST_FIN2: cmd.op = OP_FIN2;
			ST_OUT:  cmd.op = sts.out_busy ? OP_NONE : OP_OUT;
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			blk_q    <= 1'b0;
			last_q   <= 1'b0;
			tail_q   <= 1'b0;
			tready_q <= 1'b1;
		end else begin
			state_q  <= state_d;
			blk_q    <= blk_d;
			last_q   <= last_d;
			tail_q   <= tail_d;
			tready_q <= (state_d == ST_IDLE);
		end
	end

	assign s_axis_tready = tready_q;

endmodule

// ----- src/mm3_dp.sv -----
// ----------------------------------------------------------------------------
// mm3_dp
// Datapath: byte packing, length count, running hash, one shared 32x32
// multiplier, seed register and the output register.
// ----------------------------------------------------------------------------
module mm3_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [7:0]    data_byte,
	input  logic          byte_valid,
	input  logic          cfg_valid,
	input  logic [31:0]   cfg_data,
	input  mm3_pkg::cmd_t cmd,
	output mm3_pkg::sts_t sts,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [31:0]   m_axis_tdata
);
	import mm3_pkg::*;

	logic [31:0] seed_q;
	logic [31:0] h_q;
	logic [23:0] pend_q;
	logic [1:0]  cnt_q;
	logic [31:0] len_q;
	logic [31:0] x_q;
	logic [31:0] out_q;
	logic        open_q;
	logic        out_vld_q;

	logic [31:0] base_h;
	logic [23:0] base_pend;
	logic [1:0]  base_cnt;
	logic [31:0] base_len;
	logic [23:0] ins_pend;
	logic        blk_done;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [31:0] prod;
	logic [31:0] mix_r;
	logic [31:0] mix_h;
	logic [31:0] fin_t;

	always_comb begin
		base_h    = open_q ? h_q : seed_q;
		base_pend = open_q ? pend_q : 24'd0;
		base_cnt  = open_q ? cnt_q : 2'd0;
		base_len  = open_q ? len_q : 32'd0;
		blk_done  = byte_valid && (base_cnt == 2'd3);
		case (base_cnt)
			2'd0:    ins_pend = {16'd0, data_byte};
			2'd1:    ins_pend = {8'd0, data_byte, base_pend[7:0]};
			2'd2:    ins_pend = {data_byte, base_pend[15:0]};
			default: ins_pend = base_pend;
		endcase
	end

	assign sts.blk_done = blk_done;
	assign sts.tail_nz  = byte_valid || (base_cnt != 2'd0);
	assign sts.out_busy = out_vld_q && !m_axis_tready;

	assign fin_t = h_q ^ (cmd.use_x ? x_q : 32'd0) ^ len_q;
	assign mix_r = {(h_q[18:0] ^ x_q[18:0]), (h_q[31:19] ^ x_q[31:19])};
	assign mix_h = (mix_r << 2) + mix_r + MM3_N;

	always_comb begin
		case (cmd.op)
			OP_SCR1: begin
				mul_a = x_q;
				mul_b = MM3_C1;
			end
			OP_SCR2: begin
				mul_a = {x_q[16:0], x_q[31:17]};
				mul_b = MM3_C2;
			end
			OP_FIN1: begin
				mul_a = fin_t ^ (fin_t >> 16);
				mul_b = MM3_F1;
			end
			OP_FIN2: begin
				mul_a = x_q ^ (x_q >> 13);
				mul_b = MM3_F2;
			end
			default: begin
				mul_a = x_q;
				mul_b = 32'd0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q    <= 32'd0;
			cnt_q     <= 2'd0;
			open_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				seed_q <= cfg_data;
			end
			if (cmd.load) begin
				open_q <= 1'b1;
				if (blk_done) begin
					cnt_q <= 2'd0;
				end else if (byte_valid) begin
					cnt_q <= base_cnt + 2'd1;
				end else begin
					cnt_q <= base_cnt;
				end
			end
			if (cmd.op == OP_OUT) begin
				open_q    <= 1'b0;
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			h_q   <= base_h;
			len_q <= base_len + {31'd0, byte_valid};
			if (blk_done) begin
				pend_q <= 24'd0;
				x_q    <= {data_byte, base_pend};
			end else if (byte_valid) begin
				pend_q <= ins_pend;
				x_q    <= {8'd0, ins_pend};
			end else begin
				pend_q <= base_pend;
				x_q    <= {8'd0, base_pend};
			end
		end
		case (cmd.op)
			OP_SCR1, OP_SCR2, OP_FIN1, OP_FIN2: x_q <= prod;
			OP_MIX: h_q   <= mix_h;
			OP_OUT: out_q <= x_q ^ (x_q >> 16);
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_q;

endmodule

// ----- src/murmur3_32_byte_stream_hash.sv -----
// ----------------------------------------------------------------------------
// murmur3_32_byte_stream_hash
// 32-bit murmur3 hash of keys that arrive one byte per transfer.
// ----------------------------------------------------------------------------
// Keys enter on the s_axis channel, one byte per transfer: tdata holds the
// byte, tuser says that the byte belongs to the key, and tlast closes the key.
// A transfer with tuser low and tlast high closes the key without a byte; one
// with both low is dropped. The finished hash leaves on m_axis, one transfer
// per key. The seed is written on the cfg channel, which is always ready, and
// is sampled at the first transfer of each key.
// A byte that does not complete a four-byte block is packed while the input
// stays ready. The fourth byte of a block drops the input ready, since the
// block passes through the single shared multiplier twice and is then mixed
// into the running hash. A closing transfer adds two multiplier passes for any
// tail bytes and two for the finalizer before the hash goes out on m_axis.
// The output register holds one hash; a stalled receiver lets the next key
// stream in and only holds the following hash back until the register drains.
// Reset clears the seed to zero, drops any open key and the pending output.
// ----------------------------------------------------------------------------
module murmur3_32_byte_stream_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic [0:0]  s_axis_tuser,   // [0] byte_valid
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] hash_value
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);
	import mm3_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	mm3_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tlast  (s_axis_tlast),
		.byte_valid    (s_axis_tuser[0]),
		.s_axis_tready (s_axis_tready),
		.sts           (sts),
		.cmd           (cmd)
	);

	mm3_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.data_byte     (s_axis_tdata),
		.byte_valid    (s_axis_tuser[0]),
		.cfg_valid     (cfg_valid),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.sts           (sts),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

// ----- src/mm3_checker.sv -----
// ----------------------------------------------------------------------------
// mm3_checker
// Port-level checks of the murmur3 hash, bound to the top level.
// ----------------------------------------------------------------------------
`include "murmur3_32_byte_stream_hash_defines.svh"

module mm3_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);

	`MM3_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata), "Stalled hash changed or vanished.")

	`MM3_ASSERT_NEXT(a_last_busy, clk, arst_n, s_axis_tvalid && s_axis_tready && s_axis_tlast,
		!s_axis_tready, "Input still ready after the closing transfer.")

	`MM3_ASSERT_SAME(a_out_after_busy, clk, arst_n, $rose(m_axis_tvalid),
		!$past(s_axis_tready), "Hash appeared without a finalization pass.")

endmodule

bind murmur3_32_byte_stream_hash mm3_checker u_mm3_checker (.*);
